// ----- rtl/least_squares_line_fit_defines.svh -----
// Assertion macros shared by the least-squares line fit RTL.
// No dependencies; include by bare file name.
`ifndef LEAST_SQUARES_LINE_FIT_DEFINES_SVH
`define LEAST_SQUARES_LINE_FIT_DEFINES_SVH

// Same-cycle implication, disabled in reset
`define LSF_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled in reset
`define LSF_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- rtl/lsf_pkg.sv -----
// Shared types and constants of the least-squares line fit.
// No dependencies.
package lsf_pkg;

   localparam int DEF_MAX_POINTS = 32;

   // field widths
   localparam int X_W      = 12;
   localparam int Y_W      = 16;
   localparam int SLOPE_W  = 32;
   localparam int ICPT_W   = 48;
   localparam int STATUS_W = 2;
   localparam int FRAC_BITS = 16;

   // quotient bits produced by the divider per coefficient
   localparam int SLOPE_QW = SLOPE_W - 1;
   localparam int ICPT_QW  = ICPT_W - 1;
   localparam int DCNT_W   = 6;

   localparam logic [STATUS_W-1:0] STATUS_OK      = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DEGEN   = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_DROPPED = 2'd2;

   // product terms, in schedule order; even terms open an accumulation
   typedef enum logic [2:0] {
      PROD_N_SXX,
      PROD_SX_SX,
      PROD_N_SXY,
      PROD_SX_SY,
      PROD_SXX_SY,
      PROD_SX_SXY
   } prod_sel_type;

   typedef enum logic {
      DIV_SLOPE,
      DIV_ICPT
   } div_sel_type;

   typedef struct packed {
      logic         accum;
      logic         clear_sums;
      logic         mul_load;
      logic         acc_clear;
      logic         mul_step;
      logic         mul_store;
      prod_sel_type prod_sel;
      logic         div_load;
      logic         div_step;
      logic         div_store;
      div_sel_type  div_sel;
      logic         out_load;
   } lsf_cmd_type;

   typedef struct packed {
      logic mul_done;
      logic out_free;
   } lsf_stat_type;

endpackage

// ----- rtl/lsf_ctrl.sv -----
// Sequencer of the least-squares line fit: collect, multiply, divide, emit.
// Depends on lsf_pkg.
module lsf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   input  logic                 req_tlast,
   output logic                 req_tready,
   input  lsf_pkg::lsf_stat_type st,
   output lsf_pkg::lsf_cmd_type  cmd
);
   import lsf_pkg::*;

   typedef enum logic [2:0] {
      S_COLLECT,
      S_MUL_LOAD,
      S_MUL_RUN,
      S_DIV_LOAD,
      S_DIV_RUN,
      S_EMIT
   } state_type;

   state_type           state_ff;
   prod_sel_type        pidx_ff;
   div_sel_type         dsel_ff;
   logic [DCNT_W-1:0]   dcnt_ff;
   logic                beat;
   logic                even_term;

   assign req_tready = (state_ff == S_COLLECT);
   assign beat       = req_tvalid && req_tready;
   assign even_term  = (pidx_ff == PROD_N_SXX) || (pidx_ff == PROD_N_SXY) ||
                       (pidx_ff == PROD_SXX_SY);

   // state and counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_COLLECT;
         pidx_ff  <= PROD_N_SXX;
         dsel_ff  <= DIV_SLOPE;
         dcnt_ff  <= '0;
      end else begin
         unique case (state_ff)
            S_COLLECT: begin
               if (beat && req_tlast) begin
                  state_ff <= S_MUL_LOAD;
                  pidx_ff  <= PROD_N_SXX;
               end
            end
            S_MUL_LOAD: state_ff <= S_MUL_RUN;
            S_MUL_RUN: begin
               if (st.mul_done) begin
                  if (pidx_ff == PROD_SX_SXY) begin
                     state_ff <= S_DIV_LOAD;
                     dsel_ff  <= DIV_SLOPE;
                  end else begin
                     pidx_ff  <= prod_sel_type'(3'(pidx_ff) + 3'd1);
                     state_ff <= S_MUL_LOAD;
                  end
               end
            end
            S_DIV_LOAD: begin
               dcnt_ff  <= (dsel_ff == DIV_SLOPE) ? DCNT_W'(SLOPE_QW) : DCNT_W'(ICPT_QW);
               state_ff <= S_DIV_RUN;
            end
            S_DIV_RUN: begin
               if (dcnt_ff == '0) begin
                  if (dsel_ff == DIV_SLOPE) begin
                     dsel_ff  <= DIV_ICPT;
                     state_ff <= S_DIV_LOAD;
                  end else begin
                     state_ff <= S_EMIT;
                  end
               end else begin
                  dcnt_ff <= dcnt_ff - DCNT_W'(1);
               end
            end
            S_EMIT: begin
               if (st.out_free) state_ff <= S_COLLECT;
            end
            default: state_ff <= S_COLLECT;
         endcase
      end
   end

   // commands to the datapath
   always_comb begin
      cmd            = '0;
      cmd.prod_sel   = pidx_ff;
      cmd.div_sel    = dsel_ff;
      cmd.accum      = beat;
      cmd.mul_load   = (state_ff == S_MUL_LOAD);
      cmd.acc_clear  = (state_ff == S_MUL_LOAD) && even_term;
      cmd.mul_step   = (state_ff == S_MUL_RUN) && !st.mul_done;
      cmd.mul_store  = (state_ff == S_MUL_RUN) && st.mul_done && !even_term;
      cmd.div_load   = (state_ff == S_DIV_LOAD);
      cmd.div_step   = (state_ff == S_DIV_RUN) && (dcnt_ff != '0);
      cmd.div_store  = (state_ff == S_DIV_RUN) && (dcnt_ff == '0);
      cmd.out_load   = (state_ff == S_EMIT) && st.out_free;
      cmd.clear_sums = cmd.out_load;
   end

endmodule

// ----- rtl/lsf_dp.sv -----
// Datapath of the least-squares line fit: running sums, shift-add multiplier,
// restoring divider and result register. Depends on lsf_pkg and the defines.
`include "least_squares_line_fit_defines.svh"

module lsf_dp #(
   parameter int MAX_POINTS = lsf_pkg::DEF_MAX_POINTS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic        [lsf_pkg::X_W-1:0]      req_x,
   input  logic signed [lsf_pkg::Y_W-1:0]      req_y,
   input  lsf_pkg::lsf_cmd_type                cmd,
   output lsf_pkg::lsf_stat_type               st,
   input  logic                                rsp_ready,
   output logic                                rsp_valid,
   output logic signed [lsf_pkg::SLOPE_W-1:0]  rsp_slope,
   output logic signed [lsf_pkg::ICPT_W-1:0]   rsp_icpt,
   output logic        [lsf_pkg::STATUS_W-1:0] rsp_status
);
   import lsf_pkg::*;

   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int LG   = $clog2(MAX_POINTS);
   localparam int SXW  = X_W + LG;
   localparam int SYW  = Y_W + LG;
   localparam int SXXW = 2 * X_W + LG;
   localparam int SXYW = X_W + Y_W + LG;
   localparam int ACCW = SXXW + SXYW + 2;
   localparam int WIDEW = ACCW + 32;

   // running sums
   logic        [CW-1:0]   cnt_ff;
   logic        [SXW-1:0]  sx_ff;
   logic signed [SYW-1:0]  sy_ff;
   logic        [SXXW-1:0] sxx_ff;
   logic signed [SXYW-1:0] sxy_ff;
   logic                   ovf_ff;
   logic        [2*X_W-1:0]      xx;
   logic signed [X_W+Y_W:0]      xy;
   logic                         full;

   assign xx   = req_x * req_x;
   assign xy   = $signed({1'b0, req_x}) * req_y;
   assign full = (cnt_ff == CW'(MAX_POINTS));

   always_ff @(posedge clock) begin
      if (reset || cmd.clear_sums) begin
         cnt_ff <= '0;
         sx_ff  <= '0;
         sy_ff  <= '0;
         sxx_ff <= '0;
         sxy_ff <= '0;
         ovf_ff <= 1'b0;
      end else if (cmd.accum) begin
         if (full) begin
            ovf_ff <= 1'b1;
         end else begin
            cnt_ff <= cnt_ff + CW'(1);
            sx_ff  <= sx_ff + SXW'(req_x);
            sy_ff  <= sy_ff + SYW'(req_y);
            sxx_ff <= sxx_ff + SXXW'(xx);
            sxy_ff <= sxy_ff + SXYW'(xy);
         end
      end
   end

   // shift-add multiplier: unsigned a times signed b, added or subtracted
   logic        [SXXW-1:0] a_ff;
   logic signed [ACCW-1:0] b_ff;
   logic signed [ACCW-1:0] acc_ff;
   logic                   sub_ff;
   logic signed [ACCW-1:0] den_ff;
   logic signed [ACCW-1:0] snum_ff;
   logic signed [ACCW-1:0] inum_ff;

   assign st.mul_done = (a_ff == '0);

   always_ff @(posedge clock) begin
      if (cmd.mul_load) begin
         if (cmd.acc_clear) acc_ff <= '0;
         unique case (cmd.prod_sel)
            PROD_N_SXX: begin
               a_ff <= SXXW'(cnt_ff); b_ff <= ACCW'($signed({1'b0, sxx_ff})); sub_ff <= 1'b0;
            end
            PROD_SX_SX: begin
               a_ff <= SXXW'(sx_ff);  b_ff <= ACCW'($signed({1'b0, sx_ff}));  sub_ff <= 1'b1;
            end
            PROD_N_SXY: begin
               a_ff <= SXXW'(cnt_ff); b_ff <= ACCW'(sxy_ff); sub_ff <= 1'b0;
            end
            PROD_SX_SY: begin
               a_ff <= SXXW'(sx_ff);  b_ff <= ACCW'(sy_ff);  sub_ff <= 1'b1;
            end
            PROD_SXX_SY: begin
               a_ff <= sxx_ff;        b_ff <= ACCW'(sy_ff);  sub_ff <= 1'b0;
            end
            PROD_SX_SXY: begin
               a_ff <= SXXW'(sx_ff);  b_ff <= ACCW'(sxy_ff); sub_ff <= 1'b1;
            end
            default: begin
               a_ff <= '0; b_ff <= '0; sub_ff <= 1'b0;
            end
         endcase
      end else if (cmd.mul_step) begin
         if (a_ff[0]) acc_ff <= sub_ff ? acc_ff - b_ff : acc_ff + b_ff;
         a_ff <= a_ff >> 1;
         b_ff <= b_ff <<< 1;
      end
      // park the finished difference
      if (cmd.mul_store) begin
         unique case (cmd.prod_sel)
            PROD_SX_SX:  den_ff  <= acc_ff;
            PROD_SX_SY:  snum_ff <= acc_ff;
            PROD_SX_SXY: inum_ff <= acc_ff;
            default: ;
         endcase
      end
   end

   // restoring divider: floor(|num| * 2^16 / den), one quotient bit a beat
   logic        [ACCW-1:0]      den_u;
   logic signed [ACCW-1:0]      num;
   logic        [ACCW-1:0]      mag;
   logic        [WIDEW-1:0]     lim;
   logic        [ACCW-1:0]      rem_ff;
   logic        [ICPT_QW-1:0]   low_ff;
   logic        [ICPT_QW-1:0]   q_ff;
   logic                        neg_ff;
   logic                        sat_ff;
   logic        [ACCW:0]        trial;
   logic                        ge;
   logic signed [SLOPE_W-1:0]   slope_ff;
   logic signed [ICPT_W-1:0]    icpt_ff;

   assign den_u = den_ff;
   assign num   = (cmd.div_sel == DIV_SLOPE) ? snum_ff : inum_ff;
   assign mag   = num[ACCW-1] ? ACCW'(-num) : ACCW'(num);
   assign lim   = (cmd.div_sel == DIV_SLOPE) ? (WIDEW'(den_u) << (SLOPE_QW - FRAC_BITS))
                                             : (WIDEW'(den_u) << (ICPT_QW - FRAC_BITS));
   assign trial = {rem_ff, low_ff[ICPT_QW-1]};
   assign ge    = (trial >= {1'b0, den_u});

   always_ff @(posedge clock) begin
      if (cmd.div_load) begin
         neg_ff <= num[ACCW-1];
         sat_ff <= (WIDEW'(mag) >= lim);
         q_ff   <= '0;
         if (cmd.div_sel == DIV_SLOPE) begin
            rem_ff <= mag >> (SLOPE_QW - FRAC_BITS);
            low_ff <= {mag[SLOPE_QW-FRAC_BITS-1:0], {(ICPT_QW-SLOPE_QW+FRAC_BITS){1'b0}}};
         end else begin
            rem_ff <= mag >> (ICPT_QW - FRAC_BITS);
            low_ff <= {mag[ICPT_QW-FRAC_BITS-1:0], {FRAC_BITS{1'b0}}};
         end
      end else if (cmd.div_step) begin
         rem_ff <= ge ? ACCW'(trial - {1'b0, den_u}) : ACCW'(trial);
         low_ff <= low_ff << 1;
         q_ff   <= {q_ff[ICPT_QW-2:0], ge};
      end
      if (cmd.div_store) begin
         if (cmd.div_sel == DIV_SLOPE) begin
            if (sat_ff)
               slope_ff <= neg_ff ? {1'b1, {(SLOPE_W-1){1'b0}}} : {1'b0, {(SLOPE_W-1){1'b1}}};
            else
               slope_ff <= neg_ff ? -$signed(q_ff[SLOPE_W-1:0]) : $signed(q_ff[SLOPE_W-1:0]);
         end else begin
            if (sat_ff)
               icpt_ff <= neg_ff ? {1'b1, {(ICPT_W-1){1'b0}}} : {1'b0, {(ICPT_W-1){1'b1}}};
            else
               icpt_ff <= neg_ff ? -$signed({1'b0, q_ff}) : $signed({1'b0, q_ff});
         end
      end
   end

   // result register
   logic rsp_valid_ff;
   logic degen;

   assign degen       = (cnt_ff < CW'(2)) || (den_ff <= 0);
   assign st.out_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid   = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_slope  <= degen ? '0 : slope_ff;
         rsp_icpt   <= degen ? '0 : icpt_ff;
         rsp_status <= degen ? STATUS_DEGEN : (ovf_ff ? STATUS_DROPPED : STATUS_OK);
      end
   end

   `LSF_ASSERT_IMP(a_cnt_cap, clock, reset, 1'b1, cnt_ff <= CW'(MAX_POINTS), "count above capacity")
   `LSF_ASSERT_NXT(a_ovf_set, clock, reset, cmd.accum && full, ovf_ff, "dropped point not flagged")
   `LSF_ASSERT_IMP(a_rem_bound, clock, reset, cmd.div_step && !sat_ff && (den_ff > 0), rem_ff < den_u, "divider remainder not below divisor")

endmodule

// ----- rtl/least_squares_line_fit.sv -----
// Top level of the least-squares line fit.
// Depends on lsf_pkg, lsf_ctrl and lsf_dp.

// Takes calibration points (12-bit code x, Q8.8 temperature y) one beat per
// cycle and, on the beat marked tlast, fits y = slope*x + intercept over the
// set: slope and intercept carry 16 fraction bits, truncated toward zero and
// saturated; status 1 marks a degenerate set (fewer than two points or all x
// equal, coefficients zero), status 2 a set beyond MAX_POINTS whose extra
// points were dropped. Points are taken at one per cycle. After the last
// point the input stalls while one shift-add multiplier forms six products
// (each stepping until its left factor, shifted right each step, is zero)
// and one restoring divider gives 31 slope and 47 intercept bits at one bit
// per cycle; it then stalls until the result is loaded, which may wait for
// the previous result to be taken.
module least_squares_line_fit #(
   parameter int MAX_POINTS = lsf_pkg::DEF_MAX_POINTS
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [11:0] x_code, [27:12] y_temp, rest zero
   input  logic        req_tlast,   // is_last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [79:0] rsp_tdata,   // [31:0] slope, [79:32] intercept
   output logic [1:0]  rsp_tuser    // [1:0] status
);
   import lsf_pkg::*;

   lsf_cmd_type  cmd;
   lsf_stat_type st;
   logic signed [SLOPE_W-1:0] slope;
   logic signed [ICPT_W-1:0]  icpt;

   lsf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .st         (st),
      .cmd        (cmd)
   );

   lsf_dp #(
      .MAX_POINTS (MAX_POINTS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .req_x      (req_tdata[X_W-1:0]),
      .req_y      ($signed(req_tdata[X_W+Y_W-1:X_W])),
      .cmd        (cmd),
      .st         (st),
      .rsp_ready  (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .rsp_slope  (slope),
      .rsp_icpt   (icpt),
      .rsp_status (rsp_tuser)
   );

   assign rsp_tdata = {icpt, slope};

endmodule

// ----- dv/least_squares_line_fit_tb.sv -----
// Self-checking testbench for the least-squares line fit.
// Depends on lsf_pkg and least_squares_line_fit; predicts each fit in SV.
module least_squares_line_fit_tb;
   import lsf_pkg::*;

   localparam int NPTS        = DEF_MAX_POINTS;
   localparam int STALL_LIMIT = 5000;
   localparam int DRAIN_WAIT  = 400;

   typedef struct {
      logic [SLOPE_W-1:0]  slope;
      logic [ICPT_W-1:0]   icpt;
      logic [STATUS_W-1:0] status;
   } fit_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [31:0] req_tdata = '0;  // [11:0] x_code, [27:12] y_temp, rest zero
   logic        req_tlast = 1'b0; // is_last
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [79:0] rsp_tdata;        // [31:0] slope, [79:32] intercept
   logic [1:0]  rsp_tuser;        // [1:0] status

   // running sums of the set being collected
   int unsigned fit_n;
   longint      fit_sx, fit_sy, fit_sxx, fit_sxy;
   bit          fit_dropped;
   fit_type     fits_due[$];

   int  errors     = 0;
   int  idle_cnt   = 0;
   int  hold_len   = 0;
   bit  quiet      = 1'b0;  // no gaps on either side while set

   always #1 clock = ~clock;

   least_squares_line_fit #(.MAX_POINTS(NPTS)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser)
   );

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // signed num / positive den, 16 fraction bits, truncated, saturated
   function automatic longint frac_quot(longint num, longint unsigned den,
                                        longint unsigned int_lim);
      bit                neg;
      longint unsigned   mag, q, r, f, full;
      neg = num < 0;
      mag = neg ? -num : num;
      q   = mag / den;
      r   = mag % den;
      f   = 0;
      if (q >= int_lim) begin
         full = int_lim << FRAC_BITS;
         return neg ? -longint'(full) : longint'(full - 1);
      end
      for (int i = 0; i < FRAC_BITS; i++) begin
         r = r << 1;
         f = f << 1;
         if (r >= den) begin
            r = r - den;
            f = f | 1;
         end
      end
      full = (q << FRAC_BITS) | f;
      return neg ? -longint'(full) : longint'(full);
   endfunction

   function automatic void clear_fit();
      fit_n = 0; fit_sx = 0; fit_sy = 0; fit_sxx = 0; fit_sxy = 0;
      fit_dropped = 1'b0;
   endfunction

   // fold one accepted point into the sums; queue the fit on the last one
   function automatic void add_point(logic [X_W-1:0] x, logic signed [Y_W-1:0] y,
                                     bit last);
      longint  xv, yv, n, den, snum, inum;
      fit_type f;
      xv = longint'(x);
      yv = longint'(y);
      if (fit_n < NPTS) begin
         fit_n++;
         fit_sx += xv; fit_sy += yv; fit_sxx += xv * xv; fit_sxy += xv * yv;
      end else
         fit_dropped = 1'b1;
      if (!last) return;
      n   = fit_n;
      den = n * fit_sxx - fit_sx * fit_sx;
      f.slope = '0; f.icpt = '0;
      if (fit_n < 2 || den <= 0)
         f.status = STATUS_DEGEN;
      else begin
         snum = n * fit_sxy - fit_sx * fit_sy;
         inum = fit_sxx * fit_sy - fit_sx * fit_sxy;
         f.slope  = SLOPE_W'(frac_quot(snum, den, 64'd1 << 15));
         f.icpt   = ICPT_W'(frac_quot(inum, den, 64'd1 << 31));
         f.status = fit_dropped ? STATUS_DROPPED : STATUS_OK;
      end
      fits_due.push_back(f);
      clear_fit();
   endfunction

   // offer one point and hold it until the beat is taken
   task automatic send_point(logic [X_W-1:0] x, logic [Y_W-1:0] y, bit last);
      int gap;
      req_tdata  <= {4'b0, y, x};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      add_point(x, y, last);
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic send_set(int len, int xlo, int xhi);
      for (int i = 0; i < len; i++)
         send_point(X_W'($urandom_range(xlo, xhi)), Y_W'($urandom), i == len - 1);
   endtask

   // result ready: random stalls, or a long hold-off when asked
   always @(posedge clock) begin
      if (hold_len > 0) begin
         rsp_tready <= 1'b0;
         hold_len   <= hold_len - 1;
      end else if (quiet)
         rsp_tready <= 1'b1;
      else
         rsp_tready <= (pick_gap() == 0);
   end

   // compare each result beat with the oldest pending fit
   always @(posedge clock) begin
      fit_type f;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (fits_due.size() == 0) begin
            $error("unexpected result beat");
            errors++;
         end else begin
            f = fits_due.pop_front();
            if (rsp_tdata[31:0] !== f.slope) begin
               $error("slope: expected %h, got %h", f.slope, rsp_tdata[31:0]);
               errors++;
            end
            if (rsp_tdata[79:32] !== f.icpt) begin
               $error("intercept: expected %h, got %h", f.icpt, rsp_tdata[79:32]);
               errors++;
            end
            if (rsp_tuser !== f.status) begin
               $error("status: expected %0d, got %0d", f.status, rsp_tuser);
               errors++;
            end
         end
      end
   end

   // watchdog: cycles without any beat on either side
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         idle_cnt <= 0;
      else
         idle_cnt <= idle_cnt + 1;
      if (idle_cnt >= STALL_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic test_directed();
      send_point(12'd100, 16'h1234, 1'b1);             // one point: degenerate
      send_point(12'd7, 16'h0100, 1'b0);                // all x equal
      send_point(12'd7, 16'hFF00, 1'b0);
      send_point(12'd7, 16'h0000, 1'b1);
      send_point(12'd0, 16'h8000, 1'b0);                // extremes, steep slope saturates
      send_point(12'd1, 16'h7FFF, 1'b1);
      send_point(12'd0, 16'h7FFF, 1'b0);                // full range, negative slope
      send_point(12'd4095, 16'h8000, 1'b1);
      send_point(12'd4095, 16'h7FFF, 1'b0);
      send_point(12'd0, 16'h0000, 1'b0);
      send_point(12'd2048, 16'h8000, 1'b1);
      send_point(12'hAAA, 16'h5555, 1'b0);
      send_point(12'h555, 16'hAAAA, 1'b1);
   endtask

   // sets at and beyond capacity, including the last point itself dropped
   task automatic test_full_set();
      send_set(NPTS + 3, 0, 4095);
      send_set(NPTS + 1, 0, 4095);
      send_set(NPTS, 0, 4095);
      for (int i = 0; i < NPTS + 2; i++)
         send_point(12'd9, Y_W'($urandom), i == NPTS + 1);
   endtask

   task automatic test_random_sets(int points);
      int done, len, lo, r;
      done = 0;
      while (done < points) begin
         r = $urandom_range(0, 99);
         if (r < 8) len = $urandom_range(1, 2);
         else if (r < 90) len = $urandom_range(3, NPTS);
         else len = $urandom_range(NPTS + 1, NPTS + 6);
         lo = $urandom_range(0, 4095);
         if ($urandom_range(0, 3) == 0)
            send_set(len, lo, (lo + 2 > 4095) ? 4095 : lo + 2);
         else
            send_set(len, 0, 4095);
         done += len;
         if ($urandom_range(0, 9) == 0) quiet = ~quiet;
      end
      quiet = 1'b0;
   endtask

   // receiver holds off while points keep coming, so the input backs up
   task automatic test_backpressure();
      hold_len = 600;
      send_set(6, 0, 4095);
      send_set(5, 0, 4095);
      send_set(4, 0, 4095);
   endtask

   initial begin
      clear_fit();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_full_set();
      test_backpressure();
      test_random_sets(1690);
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (fits_due.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);
      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
